@@ hw/rtl/dpcr_pkg.sv @@
package dpcr_pkg;

  localparam int COORD_W     = 24;
  localparam int DIAM_W      = 16;
  localparam int MASS_W      = 16;
  localparam int DIST_FRAC   = 8;
  localparam int DF_W        = COORD_W + 3;
  localparam int DX_W        = DIAM_W + 2;
  localparam int AX_W        = DX_W - 1;
  localparam int S_W         = DIAM_W + 1;
  localparam int Q_W         = 2 * S_W;
  localparam int SQ_X_W      = Q_W + 2 * DIST_FRAC;
  localparam int SQ_R_W      = SQ_X_W + 1;
  localparam int DQ_W        = S_W + DIST_FRAC;
  localparam int SQ_LAT      = DQ_W;
  localparam int PN_W        = AX_W + DQ_W;
  localparam int MX_W        = COORD_W + 1 + DX_W;
  localparam int PM_W        = MX_W + MASS_W;
  localparam int VN_W        = PM_W + AX_W;
  localparam int DIV_NUM_W   = VN_W + 2;
  localparam int DIV_DEN_W   = S_W + Q_W;
  localparam int DIV_Q_W     = COORD_W + 2;
  localparam int DIV_LAT     = DIV_Q_W + 1;
  localparam int N_DIV       = 6;
  localparam int SAT_IN_W    = COORD_W + 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pax, pay, pbx, pby, vax, vay, vbx, vby;
  } dpcr_kin_t;

  typedef struct packed {
    dpcr_kin_t         kin;
    logic [DIAM_W-1:0] da, db;
    logic [MASS_W-1:0] ma, mb;
  } dpcr_in_t;

  typedef struct packed {
    logic                   hit, work, vwork;
    logic signed [DX_W-1:0] dx, dy;
    logic [S_W-1:0]         s;
    logic [Q_W-1:0]         q;
    logic [MASS_W-1:0]      ma, mb;
    dpcr_kin_t              kin;
  } dpcr_entry_t;

  typedef struct packed {
    logic              hit, work, vwork, sx, sy, sdot;
    logic [AX_W-1:0]   ax, ay;
    logic [MASS_W-1:0] ma, mb;
    dpcr_kin_t         kin;
  } dpcr_ctx_t;

  typedef struct packed {
    logic      hit;
    dpcr_kin_t kin;
  } dpcr_res_t;

  function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-COORD_W:0] hi_bits;
    hi_bits = v[SAT_IN_W-1:COORD_W-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      return v[COORD_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ hw/rtl/disc_pair_collision_response_unit.sv @@
// channel | handshake            | word
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_stall   | corners, diameters, velocities, masses of A, B
// out     | out_valid / out_stall | hit, new corners, new velocities of A, B
//
// One disc pair per cycle sustained while out_stall stays low; each result passes the
// 25-stage square root and the 27-stage dividers of the back pipeline.
// Synchronous active-high reset clears all valid flags and the queue pointers.
// out_stall freezes the back pipeline only; the front keeps taking words until
// the 4-entry queue and both front stages fill, then in_stall rises.
module disc_pair_collision_response_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [23:0]            pos_a_x,
  input  logic [23:0]            pos_a_y,
  input  logic [15:0]            diam_a,
  input  logic [23:0]            vel_a_x,
  input  logic [23:0]            vel_a_y,
  input  logic [15:0]            mass_a,
  input  logic [23:0]            pos_b_x,
  input  logic [23:0]            pos_b_y,
  input  logic [15:0]            diam_b,
  input  logic [23:0]            vel_b_x,
  input  logic [23:0]            vel_b_y,
  input  logic [15:0]            mass_b,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [23:0]            new_pos_a_x,
  output logic [23:0]            new_pos_a_y,
  output logic [23:0]            new_pos_b_x,
  output logic [23:0]            new_pos_b_y,
  output logic [23:0]            new_vel_a_x,
  output logic [23:0]            new_vel_a_y,
  output logic [23:0]            new_vel_b_x,
  output logic [23:0]            new_vel_b_y
);
  import dpcr_pkg::*;

  dpcr_in_t    in_word;
  dpcr_entry_t push_entry, head_entry;
  dpcr_res_t   res;
  logic        push_valid, q_full, pop, head_valid;

  always_comb begin
    in_word.kin.pax = pos_a_x;
    in_word.kin.pay = pos_a_y;
    in_word.kin.pbx = pos_b_x;
    in_word.kin.pby = pos_b_y;
    in_word.kin.vax = vel_a_x;
    in_word.kin.vay = vel_a_y;
    in_word.kin.vbx = vel_b_x;
    in_word.kin.vby = vel_b_y;
    in_word.da      = diam_a;
    in_word.db      = diam_b;
    in_word.ma      = mass_a;
    in_word.mb      = mass_b;
  end

  dpcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  dpcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  dpcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_stall  (out_stall),
    .res_valid  (out_valid),
    .res        (res)
  );

  assign hit         = res.hit;
  assign new_pos_a_x = res.kin.pax;
  assign new_pos_a_y = res.kin.pay;
  assign new_pos_b_x = res.kin.pbx;
  assign new_pos_b_y = res.kin.pby;
  assign new_vel_a_x = res.kin.vax;
  assign new_vel_a_y = res.kin.vay;
  assign new_vel_b_x = res.kin.vbx;
  assign new_vel_b_y = res.kin.vby;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled while the queue has room");

  a_pop_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(out_valid && out_stall))
    else $error("queue popped while the back pipeline is frozen");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    q_full |-> head_valid)
    else $error("queue full but no head word");

endmodule

@@ hw/rtl/dpcr_front.sv @@
module dpcr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  dpcr_pkg::dpcr_in_t   in_word,
  output logic                 in_stall,
  output logic                 push_valid,
  output dpcr_pkg::dpcr_entry_t push_entry,
  input  logic                 q_full
);
  import dpcr_pkg::*;

  logic                   f1_valid, f2_valid, f1_adv, f2_adv;
  dpcr_in_t               f1_word;
  logic signed [DF_W-1:0] f1_dx, f1_dy, dx_c, dy_c;
  logic [S_W-1:0]         f1_s;
  logic [DF_W-1:0]        adx, ady;
  logic                   in_rng, hit_c, nz_c;
  logic signed [DX_W-1:0] dxn, dyn;
  logic signed [2*DX_W-1:0] sqx, sqy;
  logic [2*DX_W-1:0]      qsum;
  logic [Q_W-1:0]         ss;

  // doubled centers keep everything integral
  always_comb begin
    dx_c = (DF_W'(in_word.kin.pax) <<< 1) + DF_W'(in_word.da)
         - (DF_W'(in_word.kin.pbx) <<< 1) - DF_W'(in_word.db);
    dy_c = (DF_W'(in_word.kin.pay) <<< 1) + DF_W'(in_word.da)
         - (DF_W'(in_word.kin.pby) <<< 1) - DF_W'(in_word.db);
  end

  always_comb begin
    adx    = f1_dx[DF_W-1] ? DF_W'(-f1_dx) : DF_W'(f1_dx);
    ady    = f1_dy[DF_W-1] ? DF_W'(-f1_dy) : DF_W'(f1_dy);
    in_rng = (adx <= DF_W'(f1_s)) && (ady <= DF_W'(f1_s));
    dxn    = f1_dx[DX_W-1:0];
    dyn    = f1_dy[DX_W-1:0];
    sqx    = dxn * dxn;
    sqy    = dyn * dyn;
    qsum   = (2*DX_W)'(sqx) + (2*DX_W)'(sqy);
    ss     = f1_s * f1_s;
    hit_c  = in_rng && (qsum <= (2*DX_W)'(ss));
    nz_c   = qsum != '0;
  end

  assign f2_adv     = !f2_valid || !q_full;
  assign f1_adv     = !f1_valid || f2_adv;
  assign in_stall   = f1_valid && !f2_adv;
  assign push_valid = f2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_adv) f1_valid <= in_valid;
      if (f2_adv) f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_adv && in_valid) begin
      f1_word <= in_word;
      f1_dx   <= dx_c;
      f1_dy   <= dy_c;
      f1_s    <= S_W'(in_word.da) + S_W'(in_word.db);
    end
    if (f2_adv && f1_valid) begin
      push_entry.hit   <= hit_c;
      push_entry.work  <= hit_c && nz_c;
      push_entry.vwork <= hit_c && nz_c && (f1_word.ma != '0 || f1_word.mb != '0);
      push_entry.dx    <= dxn;
      push_entry.dy    <= dyn;
      push_entry.s     <= f1_s;
      push_entry.q     <= qsum[Q_W-1:0];
      push_entry.ma    <= f1_word.ma;
      push_entry.mb    <= f1_word.mb;
      push_entry.kin   <= f1_word.kin;
    end
  end

endmodule

@@ hw/rtl/dpcr_queue.sv @@
module dpcr_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  dpcr_pkg::dpcr_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output dpcr_pkg::dpcr_entry_t head_entry
);
  import dpcr_pkg::*;

  dpcr_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = mem[rd_ptr];
  assign push       = push_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

endmodule

@@ hw/rtl/dpcr_sqrt.sv @@
module dpcr_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dpcr_pkg::SQ_X_W-1:0] x,
  output logic [dpcr_pkg::DQ_W-1:0]   root
);
  import dpcr_pkg::*;

  logic [SQ_R_W-1:0] rem_q  [SQ_LAT];
  logic [DQ_W-1:0]   root_q [SQ_LAT];

  // one root bit per stage, remainder form
  for (genvar i = 0; i < SQ_LAT; i++) begin : g_st
    logic [SQ_R_W-1:0] rem_in, trial;
    logic [DQ_W-1:0]   root_in;
    if (i == 0) begin : g_first
      assign rem_in  = SQ_R_W'(x);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end
    assign trial = (SQ_R_W'(root_in) << (DQ_W - i)) + (SQ_R_W'(1) << (2 * (DQ_W - 1 - i)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[i]  <= rem_in - trial;
          root_q[i] <= root_in | (DQ_W'(1) << (DQ_W - 1 - i));
        end else begin
          rem_q[i]  <= rem_in;
          root_q[i] <= root_in;
        end
      end
    end
  end

  assign root = root_q[SQ_LAT-1];

endmodule

@@ hw/rtl/dpcr_div.sv @@
module dpcr_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [dpcr_pkg::DIV_NUM_W-1:0] num,
  input  logic [dpcr_pkg::DIV_DEN_W-1:0] den,
  output logic [dpcr_pkg::DIV_Q_W-1:0]   quo
);
  import dpcr_pkg::*;

  logic [DIV_DEN_W-1:0] rem_q [DIV_LAT];
  logic [DIV_DEN_W-1:0] den_q [DIV_LAT];
  logic [DIV_Q_W-1:0]   low_q [DIV_LAT];
  logic [DIV_Q_W-1:0]   q_q   [DIV_LAT];
  logic [DIV_LAT-1:0]   ovf_q;

  // quotient too large for the result: flag it, it saturates later
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0] <= num[DIV_NUM_W-1:DIV_Q_W] >= (DIV_NUM_W-DIV_Q_W)'(den);
      rem_q[0] <= num[DIV_Q_W+DIV_DEN_W-1:DIV_Q_W];
      low_q[0] <= num[DIV_Q_W-1:0];
      den_q[0] <= den;
      q_q[0]   <= '0;
    end
  end

  for (genvar i = 1; i < DIV_LAT; i++) begin : g_st
    logic [DIV_DEN_W:0] t;
    logic               ge;
    assign t  = {rem_q[i-1], low_q[i-1][DIV_Q_W-i]};
    assign ge = t >= {1'b0, den_q[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= ge ? DIV_DEN_W'(t - {1'b0, den_q[i-1]}) : DIV_DEN_W'(t);
        q_q[i]   <= q_q[i-1] | (ge ? (DIV_Q_W'(1) << (DIV_Q_W - i)) : '0);
        low_q[i] <= low_q[i-1];
        den_q[i] <= den_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign quo = ovf_q[DIV_LAT-1] ? '1 : q_q[DIV_LAT-1];

endmodule

@@ hw/rtl/dpcr_back.sv @@
module dpcr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  dpcr_pkg::dpcr_entry_t head_entry,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  res_valid,
  output dpcr_pkg::dpcr_res_t   res
);
  import dpcr_pkg::*;

  logic adv;

  logic        e0_valid;
  dpcr_entry_t e0;

  logic [DQ_W-1:0]   dq;
  logic [SQ_LAT-1:0] sd_valid;
  dpcr_entry_t       sd [SQ_LAT];
  dpcr_entry_t       a;

  logic [AX_W-1:0]         ax_c, ay_c;
  logic [DQ_W-1:0]         gap_c;
  logic signed [COORD_W:0] dvx_c, dvy_c;
  logic [S_W-1:0]          msum_c;

  logic                   a_valid;
  dpcr_ctx_t              a_ctx;
  logic [PN_W-1:0]        a_pnx, a_pny;
  logic [DQ_W-1:0]        a_dq;
  logic signed [MX_W-1:0] a_mx, a_my;
  logic [DIV_DEN_W-1:0]   a_vden;

  logic signed [MX_W:0]   dot_c;
  dpcr_ctx_t              b_ctx_c;
  logic                   b_valid;
  dpcr_ctx_t              b_ctx;
  logic [MX_W-1:0]        b_adot;
  logic [PN_W:0]          b_pnx, b_pny;
  logic [DQ_W:0]          b_pden;
  logic [DIV_DEN_W-1:0]   b_vden;

  logic                   c_valid;
  dpcr_ctx_t              c_ctx;
  logic [PM_W-1:0]        c_pb, c_pa;
  logic [PN_W:0]          c_pnx, c_pny;
  logic [DQ_W:0]          c_pden;
  logic [DIV_DEN_W-1:0]   c_vden;

  logic                   d_valid;
  dpcr_ctx_t              d_ctx;
  logic [VN_W-1:0]        d_nxb, d_nyb, d_nxa, d_nya;
  logic [PN_W:0]          d_pnx, d_pny;
  logic [DQ_W:0]          d_pden;
  logic [DIV_DEN_W-1:0]   d_vden;

  logic                   e_valid;
  dpcr_ctx_t              e_ctx;
  logic [DIV_NUM_W-1:0]   e_num [N_DIV];
  logic [DIV_DEN_W-1:0]   e_pden, e_vden;

  logic [DIV_Q_W-1:0]     quo [N_DIV];
  logic [DIV_LAT-1:0]     dd_valid;
  dpcr_ctx_t              dd_ctx [DIV_LAT];
  dpcr_ctx_t              f;

  logic signed [DIV_Q_W:0] cx, cy, tvx_b, tvy_b, tvx_a, tvy_a;
  logic                    nx, ny;
  dpcr_res_t               res_c;

  assign adv = !(res_valid && out_stall);
  assign pop = head_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid <= 1'b0;
      sd_valid <= '0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
      e_valid  <= 1'b0;
      dd_valid <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      e0_valid  <= pop;
      sd_valid  <= {sd_valid[SQ_LAT-2:0], e0_valid};
      a_valid   <= sd_valid[SQ_LAT-1];
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      dd_valid  <= {dd_valid[DIV_LAT-2:0], e_valid};
      res_valid <= dd_valid[DIV_LAT-1];
    end
  end

  // distance: doubled center distance with DIST_FRAC fraction bits
  dpcr_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .x    ({e0.q, {(2*DIST_FRAC){1'b0}}}),
    .root (dq)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      e0    <= head_entry;
      sd[0] <= e0;
      for (int k = 1; k < SQ_LAT; k++) sd[k] <= sd[k-1];
    end
  end

  assign a = sd[SQ_LAT-1];

  always_comb begin
    ax_c   = a.dx[DX_W-1] ? AX_W'(-a.dx) : AX_W'(a.dx);
    ay_c   = a.dy[DX_W-1] ? AX_W'(-a.dy) : AX_W'(a.dy);
    gap_c  = {a.s, {DIST_FRAC{1'b0}}} - dq;
    dvx_c  = (COORD_W+1)'(a.kin.vax) - (COORD_W+1)'(a.kin.vbx);
    dvy_c  = (COORD_W+1)'(a.kin.vay) - (COORD_W+1)'(a.kin.vby);
    msum_c = S_W'(a.ma) + S_W'(a.mb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctx.hit   <= a.hit;
      a_ctx.work  <= a.work;
      a_ctx.vwork <= a.vwork;
      a_ctx.sx    <= a.dx[DX_W-1];
      a_ctx.sy    <= a.dy[DX_W-1];
      a_ctx.sdot  <= 1'b0;
      a_ctx.ax    <= ax_c;
      a_ctx.ay    <= ay_c;
      a_ctx.ma    <= a.ma;
      a_ctx.mb    <= a.mb;
      a_ctx.kin   <= a.kin;
      a_pnx       <= ax_c * gap_c;
      a_pny       <= ay_c * gap_c;
      a_dq        <= dq;
      a_mx        <= dvx_c * a.dx;
      a_my        <= dvy_c * a.dy;
      a_vden      <= msum_c * a.q;
    end
  end

  assign dot_c = (MX_W+1)'(a_mx) + (MX_W+1)'(a_my);

  always_comb begin
    b_ctx_c      = a_ctx;
    b_ctx_c.sdot = dot_c[MX_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctx      <= b_ctx_c;
      b_adot     <= dot_c[MX_W] ? MX_W'(-dot_c) : MX_W'(dot_c);
      b_pnx      <= (PN_W+1)'(a_pnx) + (PN_W+1)'(a_dq);
      b_pny      <= (PN_W+1)'(a_pny) + (PN_W+1)'(a_dq);
      b_pden     <= {a_dq, 1'b0};
      b_vden     <= a_vden;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctx  <= b_ctx;
      c_pb   <= b_adot * b_ctx.mb;
      c_pa   <= b_adot * b_ctx.ma;
      c_pnx  <= b_pnx;
      c_pny  <= b_pny;
      c_pden <= b_pden;
      c_vden <= b_vden;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_ctx  <= c_ctx;
      d_nxb  <= c_pb * c_ctx.ax;
      d_nyb  <= c_pb * c_ctx.ay;
      d_nxa  <= c_pa * c_ctx.ax;
      d_nya  <= c_pa * c_ctx.ay;
      d_pnx  <= c_pnx;
      d_pny  <= c_pny;
      d_pden <= c_pden;
      d_vden <= c_vden;
    end
  end

  // numerators carry half the divisor for round to nearest
  always_ff @(posedge clk) begin
    if (adv) begin
      e_ctx    <= d_ctx;
      e_num[0] <= DIV_NUM_W'(d_pnx);
      e_num[1] <= DIV_NUM_W'(d_pny);
      e_num[2] <= DIV_NUM_W'({d_nxb, 1'b0}) + DIV_NUM_W'(d_vden >> 1);
      e_num[3] <= DIV_NUM_W'({d_nyb, 1'b0}) + DIV_NUM_W'(d_vden >> 1);
      e_num[4] <= DIV_NUM_W'({d_nxa, 1'b0}) + DIV_NUM_W'(d_vden >> 1);
      e_num[5] <= DIV_NUM_W'({d_nya, 1'b0}) + DIV_NUM_W'(d_vden >> 1);
      e_pden   <= DIV_DEN_W'(d_pden);
      e_vden   <= d_vden;
    end
  end

  for (genvar k = 0; k < N_DIV; k++) begin : g_div
    dpcr_div u_div (
      .clk (clk),
      .en  (adv),
      .num (e_num[k]),
      .den ((k < 2) ? e_pden : e_vden),
      .quo (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_ctx[0] <= e_ctx;
      for (int k = 1; k < DIV_LAT; k++) dd_ctx[k] <= dd_ctx[k-1];
    end
  end

  assign f = dd_ctx[DIV_LAT-1];

  always_comb begin
    nx    = f.sdot ^ f.sx;
    ny    = f.sdot ^ f.sy;
    cx    = f.sx ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
    cy    = f.sy ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
    tvx_b = nx ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});
    tvy_b = ny ? -$signed({1'b0, quo[3]}) : $signed({1'b0, quo[3]});
    tvx_a = nx ? -$signed({1'b0, quo[4]}) : $signed({1'b0, quo[4]});
    tvy_a = ny ? -$signed({1'b0, quo[5]}) : $signed({1'b0, quo[5]});
    res_c.hit = f.hit;
    res_c.kin = f.kin;
    if (f.work) begin
      res_c.kin.pax = sat_coord(SAT_IN_W'(f.kin.pax) + SAT_IN_W'(cx));
      res_c.kin.pay = sat_coord(SAT_IN_W'(f.kin.pay) + SAT_IN_W'(cy));
      res_c.kin.pbx = sat_coord(SAT_IN_W'(f.kin.pbx) - SAT_IN_W'(cx));
      res_c.kin.pby = sat_coord(SAT_IN_W'(f.kin.pby) - SAT_IN_W'(cy));
    end
    if (f.vwork) begin
      res_c.kin.vax = sat_coord(SAT_IN_W'(f.kin.vax) - SAT_IN_W'(tvx_b));
      res_c.kin.vay = sat_coord(SAT_IN_W'(f.kin.vay) - SAT_IN_W'(tvy_b));
      res_c.kin.vbx = sat_coord(SAT_IN_W'(f.kin.vbx) + SAT_IN_W'(tvx_a));
      res_c.kin.vby = sat_coord(SAT_IN_W'(f.kin.vby) + SAT_IN_W'(tvy_a));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res <= res_c;
  end

endmodule

@@ tb/disc_pair_collision_response_unit_tb.sv @@
`timescale 1ns / 100ps

module disc_pair_collision_response_unit_tb;
  import dpcr_pkg::*;

  localparam longint C_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint C_MIN = -C_MAX - 1;

  typedef struct {
    dpcr_in_t word;
    bit       typed;
    bit       hit_exp;
  } pair_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [23:0] pos_a_x, pos_a_y, vel_a_x, vel_a_y, pos_b_x, pos_b_y, vel_b_x, vel_b_y;
  logic [15:0] diam_a, mass_a, diam_b, mass_b;
  logic out_valid;
  logic out_stall;
  logic hit;
  logic [23:0] new_pos_a_x, new_pos_a_y, new_pos_b_x, new_pos_b_y;
  logic [23:0] new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y;

  dpcr_res_t response_q[$];
  pair_row_t pair_rows[$];
  int        n_errors;
  int        stall_pct;

  disc_pair_collision_response_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .diam_a(diam_a),
    .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .mass_a(mass_a),
    .pos_b_x(pos_b_x), .pos_b_y(pos_b_y), .diam_b(diam_b),
    .vel_b_x(vel_b_x), .vel_b_y(vel_b_y), .mass_b(mass_b),
    .out_valid(out_valid), .out_stall(out_stall), .hit(hit),
    .new_pos_a_x(new_pos_a_x), .new_pos_a_y(new_pos_a_y),
    .new_pos_b_x(new_pos_b_x), .new_pos_b_y(new_pos_b_y),
    .new_vel_a_x(new_vel_a_x), .new_vel_a_y(new_vel_a_y),
    .new_vel_b_x(new_vel_b_x), .new_vel_b_y(new_vel_b_y)
  );

  function automatic coord_t clamp_coord(longint v);
    if (v > C_MAX) return coord_t'(C_MAX);
    if (v < C_MIN) return coord_t'(C_MIN);
    return coord_t'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // round(a*b/den) to nearest, ties away from zero, with sign applied after
  function automatic longint scaled_ratio(bit neg, longint unsigned a, longint unsigned b,
                                          longint unsigned den);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + {64'd0, den >> 1}) / {64'd0, den};
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic dpcr_res_t resolve_pair(dpcr_in_t w);
    dpcr_res_t r;
    longint pax, pay, pbx, pby, vax, vay, vbx, vby, da, db, dx, dy, s, cx, cy, dot;
    longint unsigned q, dq, gap, msum, den, adot, ax, ay, ma, mb;
    bit nx, ny;
    pax = w.kin.pax; pay = w.kin.pay; pbx = w.kin.pbx; pby = w.kin.pby;
    vax = w.kin.vax; vay = w.kin.vay; vbx = w.kin.vbx; vby = w.kin.vby;
    da = w.da; db = w.db; ma = w.ma; mb = w.mb;
    dx = (2 * pax + da) - (2 * pbx + db);
    dy = (2 * pay + da) - (2 * pby + db);
    s = da + db;
    r.kin = w.kin;
    r.hit = 1'b0;
    q = 0;
    if (mag(dx) <= s && mag(dy) <= s) begin
      q = dx * dx + dy * dy;
      r.hit = q <= s * s;
    end
    if (r.hit && q != 0) begin
      dq = root_floor(q << (2 * DIST_FRAC));
      gap = (s << DIST_FRAC) - dq;
      cx = scaled_ratio(dx < 0, mag(dx), gap, 2 * dq);
      cy = scaled_ratio(dy < 0, mag(dy), gap, 2 * dq);
      r.kin.pax = clamp_coord(pax + cx);
      r.kin.pay = clamp_coord(pay + cy);
      r.kin.pbx = clamp_coord(pbx - cx);
      r.kin.pby = clamp_coord(pby - cy);
      msum = ma + mb;
      if (msum != 0) begin
        dot = (vax - vbx) * dx + (vay - vby) * dy;
        den = msum * q;
        adot = mag(dot);
        nx = (dot < 0) != (dx < 0);
        ny = (dot < 0) != (dy < 0);
        ax = mag(dx);
        ay = mag(dy);
        r.kin.vax = clamp_coord(vax - scaled_ratio(nx, adot, ax * 2 * mb, den));
        r.kin.vay = clamp_coord(vay - scaled_ratio(ny, adot, ay * 2 * mb, den));
        r.kin.vbx = clamp_coord(vbx + scaled_ratio(nx, adot, ax * 2 * ma, den));
        r.kin.vby = clamp_coord(vby + scaled_ratio(ny, adot, ay * 2 * ma, den));
      end
    end
    return r;
  endfunction

  function automatic dpcr_in_t build_pair(longint pax, longint pay, longint da, longint vax,
                                          longint vay, longint ma, longint pbx, longint pby,
                                          longint db, longint vbx, longint vby, longint mb);
    dpcr_in_t w;
    w.kin.pax = coord_t'(pax); w.kin.pay = coord_t'(pay);
    w.kin.vax = coord_t'(vax); w.kin.vay = coord_t'(vay);
    w.kin.pbx = coord_t'(pbx); w.kin.pby = coord_t'(pby);
    w.kin.vbx = coord_t'(vbx); w.kin.vby = coord_t'(vby);
    w.da = 16'(da); w.db = 16'(db); w.ma = 16'(ma); w.mb = 16'(mb);
    return w;
  endfunction

  task automatic add_row(dpcr_in_t w, bit typed, bit hit_exp);
    pair_row_t row;
    row.word = w;
    row.typed = typed;
    row.hit_exp = hit_exp;
    pair_rows.insert(pair_rows.size(), row);
  endtask

  function automatic dpcr_in_t random_pair();
    dpcr_in_t w;
    longint span, off;
    int mode;
    mode = $urandom_range(0, 99);
    w.kin = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w.da = 16'($urandom);
    w.db = 16'($urandom);
    w.ma = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    w.mb = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
    if (mode < 40) begin
      w.da = 16'($urandom_range(0, 4095));
      w.db = 16'($urandom_range(0, 4095));
    end
    if ($urandom_range(0, 1) == 1) begin
      w.kin.vax = coord_t'(int'($urandom_range(0, 8191)) - 4096);
      w.kin.vay = coord_t'(int'($urandom_range(0, 8191)) - 4096);
      w.kin.vbx = coord_t'(int'($urandom_range(0, 8191)) - 4096);
      w.kin.vby = coord_t'(int'($urandom_range(0, 8191)) - 4096);
    end
    if (mode < 85) begin
      if (mode < 10) w.kin.pbx = coord_t'(C_MAX - $urandom_range(0, 70000));
      if (mode >= 75) w.kin.pby = coord_t'(C_MIN + $urandom_range(0, 70000));
      span = (longint'(w.da) + longint'(w.db)) / 2 + 4;
      off = longint'($urandom_range(0, 2 * span)) - span;
      w.kin.pax = coord_t'(longint'(w.kin.pbx) + off);
      off = longint'($urandom_range(0, 2 * span)) - span;
      w.kin.pay = coord_t'(longint'(w.kin.pby) + off);
    end
    return w;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_pair(dpcr_in_t w, int gap, dpcr_res_t exp_res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pos_a_x <= w.kin.pax; pos_a_y <= w.kin.pay; diam_a <= w.da;
    vel_a_x <= w.kin.vax; vel_a_y <= w.kin.vay; mass_a <= w.ma;
    pos_b_x <= w.kin.pbx; pos_b_y <= w.kin.pby; diam_b <= w.db;
    vel_b_x <= w.kin.vbx; vel_b_y <= w.kin.vby; mass_b <= w.mb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    response_q.insert(response_q.size(), exp_res);
  endtask

  task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output stall, with phases from none to heavy
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    stall_pct = 0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 15;
        2: stall_pct = 50;
        default: stall_pct = 95;
      endcase
    end
  end

  always @(posedge clk) begin
    dpcr_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (response_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected word: hit %b", $time, hit);
      end else begin
        e = response_q.pop_front();
        check_field("hit", {23'd0, e.hit}, {23'd0, hit});
        check_field("new_pos_a_x", e.kin.pax, new_pos_a_x);
        check_field("new_pos_a_y", e.kin.pay, new_pos_a_y);
        check_field("new_pos_b_x", e.kin.pbx, new_pos_b_x);
        check_field("new_pos_b_y", e.kin.pby, new_pos_b_y);
        check_field("new_vel_a_x", e.kin.vax, new_vel_a_x);
        check_field("new_vel_a_y", e.kin.vay, new_vel_a_y);
        check_field("new_vel_b_x", e.kin.vbx, new_vel_b_x);
        check_field("new_vel_b_y", e.kin.vby, new_vel_b_y);
      end
    end
  end

  initial begin
    dpcr_res_t e;
    n_errors = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    {pos_a_x, pos_a_y, vel_a_x, vel_a_y, pos_b_x, pos_b_y, vel_b_x, vel_b_y} = '0;
    {diam_a, mass_a, diam_b, mass_b} = '0;

    // far apart at the coordinate extremes: pass through
    add_row(build_pair(C_MAX, C_MAX, 65535, C_MAX, C_MAX, 65535,
                       C_MIN, C_MIN, 65535, C_MIN, C_MIN, 65535), 1, 0);
    add_row(build_pair(C_MIN, 0, 0, C_MIN, C_MAX, 1, C_MAX, 0, 0, C_MAX, C_MIN, 1), 1, 0);
    // coincident centers: hit, nothing moves
    add_row(build_pair(1000, -2000, 512, 300, -40, 7, 1128, -1872, 256, -9, 77, 3), 1, 1);
    add_row(build_pair(C_MAX, C_MIN, 0, C_MIN, C_MAX, 65535,
                       C_MAX, C_MIN, 0, C_MAX, C_MIN, 65535), 1, 1);
    // inside the box but off the circle: miss
    add_row(build_pair(0, 0, 256, 100, 0, 5, 200, 200, 256, -100, 0, 5), 1, 0);
    // just touching
    add_row(build_pair(0, 0, 256, 512, 0, 1, 256, 0, 256, -512, 0, 1), 0, 0);
    // overlap, both masses zero
    add_row(build_pair(0, 0, 512, 256, 256, 0, 100, 50, 512, -256, 0, 0), 0, 0);
    // one mass zero
    add_row(build_pair(0, 0, 512, 256, 256, 0, 100, 50, 512, -256, 0, 9), 0, 0);
    // heavy against light, max diameters
    add_row(build_pair(10, -10, 65535, 4000, -300, 65535, 900, 700, 65535, -5000, 200, 1),
            0, 0);
    // push-out and impulse into saturation
    add_row(build_pair(C_MAX - 10, C_MAX - 10, 65535, C_MAX, C_MAX, 1,
                       C_MAX - 300, C_MAX - 200, 65535, C_MIN, C_MIN, 65535), 0, 0);
    add_row(build_pair(C_MIN, C_MIN, 65535, C_MIN, C_MIN, 65535,
                       C_MIN + 400, C_MIN + 30, 65535, C_MAX, C_MAX, 1), 0, 0);
    add_row(build_pair(-5, 7, 3, 1, -1, 2, -6, 8, 1, 0, 0, 3), 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pair_rows[i]) begin
      if (pair_rows[i].typed) begin
        e.hit = pair_rows[i].hit_exp;
        e.kin = pair_rows[i].word.kin;
      end else begin
        e = resolve_pair(pair_rows[i].word);
      end
      send_pair(pair_rows[i].word, pick_gap(), e);
    end

    for (int n = 0; n < 850; n++) begin
      dpcr_in_t w;
      w = random_pair();
      if (n == 400) begin
        in_valid <= 1'b0;
        wait (response_q.size() == 0);
        @(posedge clk);
      end
      send_pair(w, (n < 150) ? 0 : pick_gap(), resolve_pair(w));
    end
    in_valid <= 1'b0;

    wait (response_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dpcr_pkg.sv
hw/rtl/dpcr_front.sv
hw/rtl/dpcr_queue.sv
hw/rtl/dpcr_sqrt.sv
hw/rtl/dpcr_div.sv
hw/rtl/dpcr_back.sv
hw/rtl/disc_pair_collision_response_unit.sv
tb/disc_pair_collision_response_unit_tb.sv
